// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, off while reset is high.
`define APBC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Checked on every rising edge, reset included.
`define APBC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define APBC_ASSERT(label, clk, rst, prop)
`define APBC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/apbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbc_pkg
// Types, register indexes, codes and helpers of the alarm panel controller.
// ----------------------------------------------------------------------------
package apbc_pkg;

  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMBO_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SHOW  = 2'd2;

  // Register reset values
  localparam logic [TICK_W-1:0] COMBO_HOLD_RST = 16'd50;
  localparam logic [TICK_W-1:0] COOLDOWN_RST   = 16'd500;
  localparam logic [TICK_W-1:0] MODE_SHOW_RST  = 16'd100;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Panel modes
  localparam logic [1:0] MODE_CONNECTED = 2'd0;
  localparam logic [1:0] MODE_CLONE     = 2'd1;
  localparam logic [1:0] MODE_DIAG      = 2'd2;

  // Local alarm phases
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_ACTIVE = 2'd1;
  localparam logic [1:0] PHASE_COOL   = 2'd2;

  typedef struct packed {
    logic left_button;
    logic right_button;
    logic light_over_limit;
    logic temp_over_limit;
    logic remote_alarm_active;
    logic remote_silence;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       sensor_select;
    logic [1:0] alarm_phase;
    logic       buzzer;
    logic       show_mode;
    logic       silence_request;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] combo_hold_ticks;
    logic [TICK_W-1:0] cooldown_ticks;
    logic [TICK_W-1:0] mode_show_ticks;
  } cfg_t;

  // Saturating tick counter increment
  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    sat_inc = (v == TICK_MAX) ? v : v + 1'b1;
  endfunction

  // connected -> clone -> diag -> connected
  function automatic logic [1:0] mode_advance(input logic [1:0] m);
    unique case (m)
      MODE_CONNECTED: mode_advance = MODE_CLONE;
      MODE_CLONE:     mode_advance = MODE_DIAG;
      default:        mode_advance = MODE_CONNECTED;
    endcase
  endfunction

endpackage

// ===== src/apbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbc_in_if / apbc_out_if
// Valid/ready channels for scan ticks and panel results.
// ----------------------------------------------------------------------------
interface apbc_in_if
  import apbc_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apbc_out_if
  import apbc_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/apbc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apbc_cfg_regs
// Timing registers written through the plain configuration write port.
// ----------------------------------------------------------------------------
module apbc_cfg_regs
  import apbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  // Register file; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.combo_hold_ticks <= COMBO_HOLD_RST;
      cfg.cooldown_ticks   <= COOLDOWN_RST;
      cfg.mode_show_ticks  <= MODE_SHOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMBO_HOLD: cfg.combo_hold_ticks <= cfg_data;
        REG_COOLDOWN:   cfg.cooldown_ticks   <= cfg_data;
        REG_MODE_SHOW:  cfg.mode_show_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/apbc_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// apbc_core
// Panel state and the per-tick update: gesture timing, button releases,
// remote silence, alarm phase and buzzer. State moves on each advance.
// ----------------------------------------------------------------------------
module apbc_core
  import apbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic [1:0]        mode, mode_next;
  logic              sensor_sel, sensor_sel_next;
  logic [1:0]        phase, phase_next;
  logic              buzzer, buzzer_next;
  logic              left_prev, right_prev;
  logic              combo_active, combo_active_next;
  logic              combo_done, combo_done_next;
  logic [TICK_W-1:0] combo_timer, combo_timer_next;
  logic [TICK_W-1:0] cooldown_timer, cooldown_timer_next;
  logic [TICK_W-1:0] show_timer, show_timer_next;
  logic              clone_silenced, clone_silenced_next;

  logic              expired;
  logic              sil_req;
  logic              show;
  logic [TICK_W-1:0] show_load;

  // One tick of panel logic
  always_comb begin
    expired             = cooldown_timer >= cfg.cooldown_ticks;
    cooldown_timer_next = sat_inc(cooldown_timer);
    mode_next           = mode;
    sensor_sel_next     = sensor_sel;
    phase_next          = phase;
    buzzer_next         = buzzer;
    combo_active_next   = combo_active;
    combo_done_next     = combo_done;
    combo_timer_next    = combo_timer;
    clone_silenced_next = clone_silenced;
    show_load           = show_timer;
    sil_req             = 1'b0;

    // two-button gesture
    if (!item.left_button && !item.right_button) begin
      if (!combo_active) begin
        combo_active_next = 1'b1;
        combo_done_next   = 1'b0;
        combo_timer_next  = '0;
      end else begin
        combo_timer_next = sat_inc(combo_timer);
        if (!combo_done && combo_timer_next >= cfg.combo_hold_ticks) begin
          mode_next       = mode_advance(mode);
          combo_done_next = 1'b1;
        end
      end
    end

    // left release: sensor toggle
    if (item.left_button && !left_prev && !combo_active_next)
      sensor_sel_next = !sensor_sel;

    // right release: clone silence, local silence, or mode window
    if (item.right_button && !right_prev && !combo_active_next) begin
      priority if (mode_next == MODE_CLONE && item.remote_alarm_active &&
                   !clone_silenced) begin
        clone_silenced_next = 1'b1;
        buzzer_next         = 1'b0;
        sil_req             = 1'b1;
      end else if (phase == PHASE_ACTIVE) begin
        phase_next          = PHASE_COOL;
        cooldown_timer_next = '0;
        expired             = 1'b0;
        buzzer_next         = 1'b0;
      end else begin
        show_load = cfg.mode_show_ticks;
      end
    end

    // gesture closes once both buttons are up
    if (item.left_button && item.right_button) begin
      combo_active_next = 1'b0;
      combo_done_next   = 1'b0;
    end

    // remote silence
    if (item.remote_silence && phase_next == PHASE_ACTIVE) begin
      phase_next          = PHASE_COOL;
      cooldown_timer_next = '0;
      expired             = 1'b0;
      buzzer_next         = 1'b0;
    end

    // per-mode alarm and buzzer work
    unique case (mode_next)
      MODE_CONNECTED: begin
        if (phase_next == PHASE_IDLE) begin
          if (item.light_over_limit || item.temp_over_limit) begin
            phase_next  = PHASE_ACTIVE;
            buzzer_next = 1'b1;
          end
        end else if (phase_next == PHASE_COOL) begin
          if (expired) phase_next = PHASE_IDLE;
        end
      end
      MODE_CLONE: begin
        buzzer_next = item.remote_alarm_active && !clone_silenced_next;
        if (!item.remote_alarm_active) clone_silenced_next = 1'b0;
      end
      default: buzzer_next = 1'b0;
    endcase

    // mode window
    show            = show_load != '0;
    show_timer_next = show ? show_load - 1'b1 : show_load;
  end

  assign result.mode            = mode_next;
  assign result.sensor_select   = sensor_sel_next;
  assign result.alarm_phase     = phase_next;
  assign result.buzzer          = buzzer_next;
  assign result.show_mode       = show;
  assign result.silence_request = sil_req;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_CONNECTED;
      sensor_sel     <= 1'b0;
      phase          <= PHASE_IDLE;
      buzzer         <= 1'b0;
      left_prev      <= 1'b1;
      right_prev     <= 1'b1;
      combo_active   <= 1'b0;
      combo_done     <= 1'b0;
      combo_timer    <= '0;
      cooldown_timer <= '0;
      show_timer     <= '0;
      clone_silenced <= 1'b0;
    end else if (advance) begin
      mode           <= mode_next;
      sensor_sel     <= sensor_sel_next;
      phase          <= phase_next;
      buzzer         <= buzzer_next;
      left_prev      <= item.left_button;
      right_prev     <= item.right_button;
      combo_active   <= combo_active_next;
      combo_done     <= combo_done_next;
      combo_timer    <= combo_timer_next;
      cooldown_timer <= cooldown_timer_next;
      show_timer     <= show_timer_next;
      clone_silenced <= clone_silenced_next;
    end
  end

  // Checks
  `APBC_ASSERT(a_mode_legal, clk, rst,
    mode == MODE_CONNECTED || mode == MODE_CLONE || mode == MODE_DIAG)
  `APBC_ASSERT(a_done_in_gesture, clk, rst, combo_done |-> combo_active)
  `APBC_ASSERT(a_sil_req_clone, clk, rst,
    advance && sil_req |-> mode_next == MODE_CLONE)
  `APBC_ASSERT(a_remote_silence, clk, rst,
    advance && item.remote_silence && phase == PHASE_ACTIVE |=> phase == PHASE_COOL)

endmodule

// ===== src/alarm_panel_button_controller_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// alarm_panel_button_controller_unit
// Button, mode and alarm-phase controller of an alarm panel, one scan tick
// per input beat and one result beat per tick.
// ----------------------------------------------------------------------------
// Takes one scan-tick beat every clock cycle while in_ch.ready is high and
// returns one result beat per tick: the tick sits in an input register, the
// panel update runs combinationally on it, and the result is held in an
// output register until taken. The panel state is updated as the tick moves
// into the output register, so ticks follow back to back with no bubble;
// in_ch.ready falls only while both registers hold beats and out_ch.ready is
// low. The timing registers are read live by the update logic and should be
// written while no tick is in flight.
module alarm_panel_button_controller_unit
  import apbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  apbc_in_if.sink              in_ch,
  apbc_out_if.source           out_ch
);

  cfg_t      cfg;
  in_item_t  s0_item;
  logic      s0_valid;
  logic      s0_adv;
  out_item_t core_result;
  out_item_t s1_item;
  logic      s1_valid;
  logic      in_take;

  apbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage handshakes
  assign s0_adv      = s0_valid && (!s1_valid || out_ch.ready);
  assign in_ch.ready = !s0_valid || s0_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s0_item <= in_ch.data;
  end

  apbc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (s0_adv),
    .item    (s0_item),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || out_ch.ready) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) s1_item <= core_result;
  end

  assign out_ch.valid = s1_valid;
  assign out_ch.data  = s1_item;

  // Checks
  `APBC_ASSERT(a_adv_fills_out, clk, rst, s0_adv |=> s1_valid)
  `APBC_ASSERT(a_stall_only_full, clk, rst,
    !in_ch.ready |-> s0_valid && s1_valid && !out_ch.ready)
  `APBC_ASSERT(a_s0_held, clk, rst, s0_valid && !s0_adv |=> s0_valid)

endmodule
